@@ rtl/mrrf_pkg.sv @@
// Shared constants for the multi-reader ring FIFO: status codes, access modes,
// field widths and default sizes. No dependencies.
`default_nettype none

package mrrf_pkg;

    localparam int DEPTH_DEF   = 64;
    localparam int READERS_DEF = 5;

    localparam int DATA_W   = 8;
    localparam int READER_W = 3;
    localparam int CFG_W    = 3;
    localparam int STATUS_W = 2;

    localparam logic [CFG_W-1:0] CFG_RESET = 3'd5;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_READ  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_INACTIVE = 2'd3;

endpackage

`default_nettype wire

@@ rtl/multi_reader_ring_fifo.sv @@
// Broadcast ring FIFO, one writer and several readers, top level.
// Depends on mrrf_pkg for status codes, widths and defaults.
`default_nettype none

// One transfer in, one result out. An item is taken every cycle while in_stall
// is low: the ring is a single-port memory addressed in the cycle of acceptance,
// and the result (status, slot and, for a good read, the byte) sits in the
// output register in the next cycle. While that result is stalled, in_stall is
// high; a result taken in the same cycle lets the next item in. Readers
// 0 .. readers_in_use-1 are active, with readers_in_use above READERS counting
// as READERS. A write needs room in every active reader, else it gets ST_FULL;
// inactive readers keep their pointer and count. No clearing pass after reset.
module multi_reader_ring_fifo #(
    parameter int DEPTH   = mrrf_pkg::DEPTH_DEF,
    parameter int READERS = mrrf_pkg::READERS_DEF,
    localparam int AW     = (DEPTH > 2) ? $clog2(DEPTH) : 1,
    localparam int CW     = $clog2(DEPTH + 1)
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,

    input  wire logic                           cfg_wr_en,
    input  wire logic [mrrf_pkg::CFG_W-1:0]     cfg_wr_data,

    input  wire logic                           in_valid,
    output      logic                           in_stall,
    input  wire logic                           mode,
    input  wire logic [mrrf_pkg::READER_W-1:0]  reader,
    input  wire logic [mrrf_pkg::DATA_W-1:0]    data_in,

    output      logic                           out_valid,
    input  wire logic                           out_stall,
    output      logic [mrrf_pkg::STATUS_W-1:0]  status,
    output      logic [mrrf_pkg::DATA_W-1:0]    data_out,
    output      logic [AW-1:0]                  slot
);

    logic [mrrf_pkg::CFG_W-1:0]    cfg_reg;

    logic [AW-1:0]                 wr_ptr_reg;
    logic [AW-1:0]                 wr_ptr_next;
    logic [AW-1:0]                 rd_ptr_reg  [READERS];
    logic [AW-1:0]                 rd_ptr_next [READERS];
    logic [CW-1:0]                 cnt_reg     [READERS];
    logic [CW-1:0]                 cnt_next    [READERS];

    logic [mrrf_pkg::DATA_W-1:0]   mem [DEPTH];
    logic [mrrf_pkg::DATA_W-1:0]   rd_data_reg;

    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [mrrf_pkg::STATUS_W-1:0] status_reg;
    logic [mrrf_pkg::STATUS_W-1:0] status_next;
    logic [AW-1:0]                 slot_reg;
    logic [AW-1:0]                 slot_next;
    logic                          rd_ok_reg;
    logic                          rd_ok_next;

    logic [READERS-1:0]            active;
    logic                          full;
    logic                          rd_active;
    logic [AW-1:0]                 sel_ptr;
    logic [CW-1:0]                 sel_cnt;
    logic                          accept;
    logic                          wr_fire;
    logic                          rd_fire;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        full    = 1'b0;
        sel_ptr = '0;
        sel_cnt = '0;
        for (int i = 0; i < READERS; i++)
        begin
            active[i] = int'(cfg_reg) > i;
            if (active[i] && cnt_reg[i] == CW'(DEPTH))
            begin
                full = 1'b1;
            end
            if (int'(reader) == i)
            begin
                sel_ptr = rd_ptr_reg[i];
                sel_cnt = cnt_reg[i];
            end
        end
        rd_active = (int'(reader) < READERS) && (int'(reader) < int'(cfg_reg));
    end

    always_comb
    begin
        rd_ok_next  = 1'b0;
        status_next = mrrf_pkg::ST_OK;
        slot_next   = '0;
        if (mode == mrrf_pkg::MODE_WRITE)
        begin
            status_next = full ? mrrf_pkg::ST_FULL : mrrf_pkg::ST_OK;
            slot_next   = wr_ptr_reg;
        end
        else if (!rd_active)
        begin
            status_next = mrrf_pkg::ST_INACTIVE;
        end
        else if (sel_cnt == '0)
        begin
            status_next = mrrf_pkg::ST_EMPTY;
            slot_next   = sel_ptr;
        end
        else
        begin
            rd_ok_next = 1'b1;
            slot_next  = sel_ptr;
        end
    end

    assign wr_fire = accept && (mode == mrrf_pkg::MODE_WRITE) && !full;
    assign rd_fire = accept && rd_ok_next;

    always_comb
    begin
        wr_ptr_next = wr_fire ? wrap_inc(wr_ptr_reg) : wr_ptr_reg;
        for (int i = 0; i < READERS; i++)
        begin
            rd_ptr_next[i] = rd_ptr_reg[i];
            cnt_next[i]    = cnt_reg[i];
            if (wr_fire && active[i])
            begin
                cnt_next[i] = cnt_reg[i] + CW'(1);
            end
            if (rd_fire && int'(reader) == i)
            begin
                rd_ptr_next[i] = wrap_inc(rd_ptr_reg[i]);
                cnt_next[i]    = cnt_reg[i] - CW'(1);
            end
        end
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg       <= mrrf_pkg::CFG_RESET;
            wr_ptr_reg    <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < READERS; i++)
            begin
                rd_ptr_reg[i] <= '0;
                cnt_reg[i]    <= '0;
            end
        end
        else
        begin
            if (cfg_wr_en)
            begin
                cfg_reg <= cfg_wr_data;
            end
            wr_ptr_reg    <= wr_ptr_next;
            out_valid_reg <= out_valid_next;
            for (int i = 0; i < READERS; i++)
            begin
                rd_ptr_reg[i] <= rd_ptr_next[i];
                cnt_reg[i]    <= cnt_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            slot_reg   <= slot_next;
            rd_ok_reg  <= rd_ok_next;
        end
    end

    // ring memory: write on a good write, registered read on a good read
    always_ff @(posedge clk)
    begin
        if (wr_fire)
        begin
            mem[wr_ptr_reg] <= data_in;
        end
        if (rd_fire)
        begin
            rd_data_reg <= mem[sel_ptr];
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign slot      = slot_reg;
    assign data_out  = rd_ok_reg ? rd_data_reg : '0;

`ifndef SYNTHESIS
    a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |=> out_valid_reg && $stable(status_reg)
            && $stable(slot_reg) && $stable(data_out))
        else $error("stalled result changed");

    a_write_advances: assert property (@(posedge clk) disable iff (!rst_n)
        wr_fire |=> wr_ptr_reg != $past(wr_ptr_reg))
        else $error("write pointer did not advance");

    a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
        rd_fire |=> out_valid_reg && status_reg == mrrf_pkg::ST_OK && rd_ok_reg)
        else $error("good read not reported");
`endif

endmodule

`default_nettype wire

@@ tb/tb_multi_reader_ring_fifo.sv @@
// Self-checking testbench for multi_reader_ring_fifo: directed table, then random
// access phases over several reader counts, checked against a built-in predictor.
// Depends on rtl/mrrf_pkg.sv and rtl/multi_reader_ring_fifo.sv.
`timescale 1ns / 1ps

module tb_multi_reader_ring_fifo;

    localparam int   SLOT_W      = $clog2(mrrf_pkg::DEPTH_DEF);
    localparam int   QUIET_LIMIT = 2000;
    localparam int   HOLD_CYCLES = 150;
    localparam int   FILL_WRITES = 70;
    localparam int   PHASE_ITEMS = 45;
    localparam int   NUM_ROWS    = 22;
    localparam int   NUM_PHASES  = 9;

    typedef logic [mrrf_pkg::READER_W-1:0] reader_id_t;
    typedef logic [mrrf_pkg::DATA_W-1:0]   byte_val_t;
    typedef logic [mrrf_pkg::CFG_W-1:0]    cfg_word_t;

    typedef struct packed {
        logic [mrrf_pkg::STATUS_W-1:0] status;
        logic [mrrf_pkg::DATA_W-1:0]   data;
        logic [SLOT_W-1:0]             slot;
    } access_result_t;

    typedef struct packed {
        logic                          m;
        logic [mrrf_pkg::READER_W-1:0] r;
        logic [mrrf_pkg::DATA_W-1:0]   d;
        logic                          fixed;
        access_result_t                want;
    } access_row_t;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          cfg_wr_en;
    logic [mrrf_pkg::CFG_W-1:0]    cfg_wr_data;
    logic                          in_valid;
    logic                          in_stall;
    logic                          mode;
    logic [mrrf_pkg::READER_W-1:0] reader;
    logic [mrrf_pkg::DATA_W-1:0]   data_in;
    logic                          out_valid;
    logic                          out_stall;
    logic [mrrf_pkg::STATUS_W-1:0] status;
    logic [mrrf_pkg::DATA_W-1:0]   data_out;
    logic [SLOT_W-1:0]             slot;

    // tag that travels with the payload: typed-in expectation or none
    logic                          item_fixed;
    access_result_t                item_expect;

    // predictor state
    logic [mrrf_pkg::DATA_W-1:0]   ring_bytes [mrrf_pkg::DEPTH_DEF] = '{default: '0};
    logic [SLOT_W-1:0]             wr_slot = '0;
    logic [SLOT_W-1:0]             rd_slot [mrrf_pkg::READERS_DEF] = '{default: '0};
    int                            fill_level [mrrf_pkg::READERS_DEF] = '{default: 0};
    logic [mrrf_pkg::CFG_W-1:0]    active_cfg = mrrf_pkg::CFG_RESET;

    access_result_t                pending_results [$];
    int                            errors = 0;
    int                            sender_idle_pct = 0;
    int                            receiver_stall_pct = 0;
    bit                            hold_req = 1'b0;
    int                            hold_left = 0;
    int                            quiet_cycles = 0;
    access_row_t                   directed_rows [NUM_ROWS];

    multi_reader_ring_fifo dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .mode       (mode),
        .reader     (reader),
        .data_in    (data_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .data_out   (data_out),
        .slot       (slot)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] p);
        return (int'(p) == mrrf_pkg::DEPTH_DEF - 1) ? '0 : p + 1'b1;
    endfunction

    function automatic int live_readers();
        return (int'(active_cfg) > mrrf_pkg::READERS_DEF) ? mrrf_pkg::READERS_DEF
                                                          : int'(active_cfg);
    endfunction

    function automatic access_result_t predict_access(
        input logic                          m,
        input logic [mrrf_pkg::READER_W-1:0] r,
        input logic [mrrf_pkg::DATA_W-1:0]   d);
        access_result_t res;
        int             n;
        bit             full;
        res  = '0;
        n    = live_readers();
        full = 1'b0;
        if (m == mrrf_pkg::MODE_WRITE)
        begin
            for (int i = 0; i < n; i++)
                if (fill_level[i] >= mrrf_pkg::DEPTH_DEF)
                    full = 1'b1;
            res.slot = wr_slot;
            if (full)
                res.status = mrrf_pkg::ST_FULL;
            else
            begin
                res.status = mrrf_pkg::ST_OK;
                ring_bytes[wr_slot] = d;
                wr_slot = next_slot(wr_slot);
                for (int i = 0; i < n; i++)
                    fill_level[i]++;
            end
        end
        else if (int'(r) >= n)
            res.status = mrrf_pkg::ST_INACTIVE;
        else
        begin
            res.slot = rd_slot[r];
            if (fill_level[r] == 0)
                res.status = mrrf_pkg::ST_EMPTY;
            else
            begin
                res.status = mrrf_pkg::ST_OK;
                res.data = ring_bytes[rd_slot[r]];
                rd_slot[r] = next_slot(rd_slot[r]);
                fill_level[r]--;
            end
        end
        return res;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    // scoreboard and predictor, both on the rising edge
    always @(posedge clk)
    begin
        access_result_t want;
        access_result_t pred;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected result, status %0d data %0d slot %0d",
                             $time, status, data_out, slot);
                    errors++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("status", want.status, status);
                    check_field("data_out", want.data, data_out);
                    check_field("slot", want.slot, slot);
                end
            end
            if (in_valid && !in_stall)
            begin
                pred = predict_access(mode, reader, data_in);
                pending_results.push_back(item_fixed ? item_expect : pred);
            end
            if (cfg_wr_en)
                active_cfg = cfg_wr_data;
        end
    end

    // result side: random stall, plus a long hold-off on request
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
        end
    end

    // watchdog: cycles with no transfer on either side
    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    // entered and left at a falling edge; valid stays high into the next call
    task automatic send_access(input logic m, input logic [mrrf_pkg::READER_W-1:0] r,
                               input logic [mrrf_pkg::DATA_W-1:0] d, input logic fixed,
                               input access_result_t want);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        mode        <= m;
        reader      <= r;
        data_in     <= d;
        item_fixed  <= fixed;
        item_expect <= want;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        @(negedge clk);
    endtask

    initial
    begin
        int         phase_cfg [NUM_PHASES];
        int         n_eff;
        int         write_pct;
        logic       m;
        reader_id_t r;
        phase_cfg   = '{1, 0, 7, 3, 5, 2, 6, 4, 5};
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        in_valid    = 1'b0;
        mode        = mrrf_pkg::MODE_WRITE;
        reader      = '0;
        data_in     = '0;
        item_fixed  = 1'b0;
        item_expect = '0;

        directed_rows = '{
            '{mrrf_pkg::MODE_READ,  3'd0, 8'h00, 1'b1, '{mrrf_pkg::ST_EMPTY,    8'h00, 6'd0}},
            '{mrrf_pkg::MODE_READ,  3'd7, 8'h00, 1'b1, '{mrrf_pkg::ST_INACTIVE, 8'h00, 6'd0}},
            '{mrrf_pkg::MODE_READ,  3'd5, 8'hFF, 1'b1, '{mrrf_pkg::ST_INACTIVE, 8'h00, 6'd0}},
            '{mrrf_pkg::MODE_WRITE, 3'd0, 8'h00, 1'b1, '{mrrf_pkg::ST_OK,       8'h00, 6'd0}},
            '{mrrf_pkg::MODE_WRITE, 3'd3, 8'hFF, 1'b1, '{mrrf_pkg::ST_OK,       8'h00, 6'd1}},
            '{mrrf_pkg::MODE_READ,  3'd0, 8'h00, 1'b1, '{mrrf_pkg::ST_OK,       8'h00, 6'd0}},
            '{mrrf_pkg::MODE_READ,  3'd0, 8'h00, 1'b1, '{mrrf_pkg::ST_OK,       8'hFF, 6'd1}},
            '{mrrf_pkg::MODE_READ,  3'd0, 8'h00, 1'b1, '{mrrf_pkg::ST_EMPTY,    8'h00, 6'd2}},
            '{mrrf_pkg::MODE_READ,  3'd4, 8'h00, 1'b1, '{mrrf_pkg::ST_OK,       8'h00, 6'd0}},
            '{mrrf_pkg::MODE_WRITE, 3'd7, 8'hA5, 1'b1, '{mrrf_pkg::ST_OK,       8'h00, 6'd2}},
            '{mrrf_pkg::MODE_READ,  3'd1, 8'h00, 1'b0, '0},
            '{mrrf_pkg::MODE_READ,  3'd2, 8'h00, 1'b0, '0},
            '{mrrf_pkg::MODE_READ,  3'd3, 8'h00, 1'b0, '0},
            '{mrrf_pkg::MODE_READ,  3'd4, 8'h00, 1'b0, '0},
            '{mrrf_pkg::MODE_READ,  3'd4, 8'h00, 1'b0, '0},
            '{mrrf_pkg::MODE_READ,  3'd4, 8'h00, 1'b0, '0},
            '{mrrf_pkg::MODE_WRITE, 3'd4, 8'h5A, 1'b0, '0},
            '{mrrf_pkg::MODE_WRITE, 3'd6, 8'h3C, 1'b0, '0},
            '{mrrf_pkg::MODE_READ,  3'd0, 8'h00, 1'b0, '0},
            '{mrrf_pkg::MODE_READ,  3'd0, 8'h00, 1'b0, '0},
            '{mrrf_pkg::MODE_READ,  3'd6, 8'h00, 1'b0, '0},
            '{mrrf_pkg::MODE_READ,  3'd1, 8'h00, 1'b0, '0}
        };

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            send_access(directed_rows[i].m, directed_rows[i].r, directed_rows[i].d,
                        directed_rows[i].fixed, directed_rows[i].want);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            drain();
            cfg_wr_en   <= 1'b1;
            cfg_wr_data <= cfg_word_t'(phase_cfg[p]);
            @(negedge clk);
            cfg_wr_en   <= 1'b0;

            case (p % 4)
                0:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
                1:
                begin
                    sender_idle_pct    = 50;
                    receiver_stall_pct = 0;
                end
                2:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 50;
                end
                default:
                begin
                    sender_idle_pct    = 29;
                    receiver_stall_pct = 29;
                end
            endcase

            n_eff = (phase_cfg[p] > mrrf_pkg::READERS_DEF) ? mrrf_pkg::READERS_DEF
                                                           : phase_cfg[p];

            // write burst past full; first one with the result side held off
            if (p == 0 || p == 4)
            begin
                if (p == 0)
                    hold_req = 1'b1;
                repeat (FILL_WRITES)
                    send_access(mrrf_pkg::MODE_WRITE, reader_id_t'($urandom_range(0, 7)),
                                byte_val_t'($urandom_range(0, 255)), 1'b0, '0);
            end

            write_pct = 50;
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if (k % 15 == 0)
                    case ($urandom_range(0, 2))
                        0: write_pct = 85;
                        1: write_pct = 50;
                        default: write_pct = 15;
                    endcase
                m = ($urandom_range(0, 99) < write_pct) ? mrrf_pkg::MODE_WRITE
                                                        : mrrf_pkg::MODE_READ;
                if (n_eff == 0 || $urandom_range(0, 3) == 0)
                    r = reader_id_t'($urandom_range(0, 7));
                else
                    r = reader_id_t'($urandom_range(0, n_eff - 1));
                send_access(m, r, byte_val_t'($urandom_range(0, 255)), 1'b0, '0);
            end
        end

        drain();
        repeat (4) @(negedge clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ multi_reader_ring_fifo.f @@
rtl/mrrf_pkg.sv
rtl/multi_reader_ring_fifo.sv
tb/tb_multi_reader_ring_fifo.sv
